@@ rtl/servo_teach_replay_controller_assert.svh @@
// Assertion macros for the servo teach and replay controller.
// Needs nothing; the top level takes it by include.
`ifndef SERVO_TEACH_REPLAY_CONTROLLER_ASSERT_SVH
`define SERVO_TEACH_REPLAY_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define STC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("servo controller: same-cycle check failed");

// next-cycle implication
`define STC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("servo controller: next-cycle check failed");

`endif

@@ rtl/stc_pkg.sv @@
// Shared types, codes and constants of the servo teach and replay controller.
// Depends on nothing; the other files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package stc_pkg;

   localparam int FRAME_DEPTH_DEFAULT = 128;
   localparam int NUM_LANES           = 4;
   localparam int SAMPLE_W            = 12;
   localparam int COMPARE_W           = 15;
   localparam int CSR_INDEX_W         = 8;
   localparam int CLAW_LANE           = 3;

   // 20000 - 500
   localparam logic [COMPARE_W-1:0] COMPARE_TOP  = 15'd19500;
   localparam logic [6:0]           SCALE_FACTOR = 7'd125;

   localparam logic [SAMPLE_W-1:0] JOINT_BAND_RESET   = 12'd200;
   localparam logic [SAMPLE_W-1:0] CLAW_LIVE_RESET    = 12'd100;
   localparam logic [SAMPLE_W-1:0] CLAW_RECORD_RESET  = 12'd200;
   localparam logic [SAMPLE_W-1:0] CLAW_RELEASE_RESET = 12'd3048;

   typedef logic [SAMPLE_W-1:0]  sample_type;
   typedef logic [COMPARE_W-1:0] compare_type;

   typedef enum logic [2:0] {
      CMD_LIVE         = 3'd0,
      CMD_START_RECORD = 3'd1,
      CMD_RECORD       = 3'd2,
      CMD_START_REPLAY = 3'd3,
      CMD_REPLAY_TICK  = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EXHAUSTED = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_JOINT_DEADBAND  = 8'd0,
      CSR_CLAW_LIVE       = 8'd1,
      CSR_CLAW_RECORD     = 8'd2,
      CSR_CLAW_RELEASE    = 8'd3
   } csr_index_type;

   typedef struct packed {
      sample_type  sample;
      compare_type compare;
   } lane_type;

   typedef struct packed {
      logic       from_frame;
      status_type status;
      logic       last_frame;
      logic       claw_released;
      logic [7:0] frames_stored;
   } rsp_ctl_type;

endpackage

@@ rtl/stc_if.sv @@
// Channel interfaces of the servo teach and replay controller: request,
// response and register write. Depends on stc_pkg.
`timescale 1ns / 1ps

interface stc_req_if;
   logic                    valid;
   logic                    ready;
   logic [2:0]              command;
   stc_pkg::sample_type     base_sample;
   stc_pkg::sample_type     shoulder_sample;
   stc_pkg::sample_type     elbow_sample;
   stc_pkg::sample_type     claw_sample;

   modport source (output valid, command, base_sample, shoulder_sample, elbow_sample,
                   claw_sample, input ready);
   modport sink (input valid, command, base_sample, shoulder_sample, elbow_sample,
                 claw_sample, output ready);
endinterface

interface stc_rsp_if;
   logic                    valid;
   logic                    ready;
   stc_pkg::compare_type    base_compare;
   stc_pkg::compare_type    shoulder_compare;
   stc_pkg::compare_type    elbow_compare;
   stc_pkg::compare_type    claw_compare;
   logic                    claw_released;
   logic [7:0]              frames_stored;
   logic [1:0]              status;
   logic                    last_frame;

   modport source (output valid, base_compare, shoulder_compare, elbow_compare,
                   claw_compare, claw_released, frames_stored, status, last_frame,
                   input ready);
   modport sink (input valid, base_compare, shoulder_compare, elbow_compare,
                 claw_compare, claw_released, frames_stored, status, last_frame,
                 output ready);
endinterface

interface stc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [stc_pkg::CSR_INDEX_W-1:0]    index;
   stc_pkg::sample_type                data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/stc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module stc_ram #(
   parameter int WIDTH = 60,
   parameter int DEPTH = 128,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/stc_lane.sv @@
// One servo channel: held sample, deadband test and compare computation.
// Depends on stc_pkg.
`timescale 1ns / 1ps

module stc_lane #(
   parameter bit IS_CLAW = 1'b0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                sample_en,
   input  stc_pkg::sample_type sample,
   input  stc_pkg::sample_type band,
   output stc_pkg::lane_type   lane_next
);

   stc_pkg::lane_type   lane_ff;
   stc_pkg::lane_type   lane_in;
   stc_pkg::sample_type delta;
   logic [18:0]         product;
   logic [10:0]         offset;

   always_comb begin
      delta   = (sample > lane_ff.sample) ? (sample - lane_ff.sample)
                                          : (lane_ff.sample - sample);
      product = 19'(sample) * 19'(stc_pkg::SCALE_FACTOR);
      offset  = IS_CLAW ? {1'b0, product[18:9]} : product[18:8];
      lane_in = lane_ff;
      if (sample_en && (delta > band)) begin
         lane_in.sample  = sample;
         lane_in.compare = stc_pkg::COMPARE_TOP - 15'(offset);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign lane_next = lane_in;

endmodule

@@ rtl/stc_merge.sv @@
// Result stage: registers the lane compares and status, and picks the
// stored frame on a replay beat. Depends on stc_pkg and stc_if.
`timescale 1ns / 1ps

module stc_merge (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           load,
   input  stc_pkg::compare_type [stc_pkg::NUM_LANES-1:0]  lane_cmp,
   input  stc_pkg::rsp_ctl_type                           ctl,
   input  stc_pkg::compare_type [stc_pkg::NUM_LANES-1:0]  frame_data,
   output logic                                           stage_free,
   stc_rsp_if.source                                      rsp
);

   logic                                          valid_ff;
   logic                                          valid_in;
   stc_pkg::compare_type [stc_pkg::NUM_LANES-1:0] cmp_ff;
   stc_pkg::rsp_ctl_type                          ctl_ff;
   stc_pkg::compare_type [stc_pkg::NUM_LANES-1:0] shown;

   always_comb begin
      stage_free = !valid_ff || rsp.ready;
      valid_in   = load || (valid_ff && !rsp.ready);
      shown      = ctl_ff.from_frame ? frame_data : cmp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmp_ff <= lane_cmp;
         ctl_ff <= ctl;
      end
   end

   assign rsp.valid            = valid_ff;
   assign rsp.base_compare     = shown[0];
   assign rsp.shoulder_compare = shown[1];
   assign rsp.elbow_compare    = shown[2];
   assign rsp.claw_compare     = shown[3];
   assign rsp.claw_released    = ctl_ff.claw_released;
   assign rsp.frames_stored    = ctl_ff.frames_stored;
   assign rsp.status           = ctl_ff.status;
   assign rsp.last_frame       = ctl_ff.last_frame;

endmodule

@@ rtl/servo_teach_replay_controller.sv @@
// Top level of the four-channel servo teach and replay controller.
// Depends on stc_pkg, stc_if, stc_lane, stc_ram, stc_merge and the assertion header.
//
// Takes one request beat per clock and returns one response beat per request,
// in the next cycle, as long as the response side keeps up; a stalled response
// holds the request side only when the single result register is full. The
// rate is set by the four channel lanes working in parallel (one deadband
// compare and one constant multiply each) and by the frame store, a memory of
// FRAME_DEPTH frames of 60 bits with one write and one registered read per
// cycle. The frame store needs no clearing pass after reset: only frames below
// the frame count are ever read. Register writes are always taken at once.
`timescale 1ns / 1ps
`include "servo_teach_replay_controller_assert.svh"

module servo_teach_replay_controller #(
   parameter int FRAME_DEPTH = stc_pkg::FRAME_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   stc_req_if.sink     req_bus,
   stc_rsp_if.source   rsp_bus,
   stc_csr_if.sink     csr_bus
);

   localparam int CW = $clog2(FRAME_DEPTH + 1);
   localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam int FW = stc_pkg::NUM_LANES * stc_pkg::COMPARE_W;
   localparam logic [CW-1:0] DEPTH_LIMIT = CW'(FRAME_DEPTH);

   stc_pkg::sample_type joint_band_ff;
   stc_pkg::sample_type claw_live_ff;
   stc_pkg::sample_type claw_record_ff;
   stc_pkg::sample_type claw_release_ff;

   logic [CW-1:0] frame_count_ff;
   logic [CW-1:0] frame_count_in;
   logic [CW-1:0] replay_ptr_ff;
   logic [CW-1:0] replay_ptr_in;
   logic [CW+7:0] count_wide;

   logic                 accept;
   logic                 stage_free;
   logic                 sample_en;
   logic                 wr_en;
   logic                 rd_en;
   stc_pkg::sample_type  claw_band;
   stc_pkg::command_type command;
   stc_pkg::rsp_ctl_type ctl;

   stc_pkg::sample_type  [stc_pkg::NUM_LANES-1:0] samples;
   stc_pkg::sample_type  [stc_pkg::NUM_LANES-1:0] bands;
   stc_pkg::lane_type    [stc_pkg::NUM_LANES-1:0] lane_next;
   stc_pkg::compare_type [stc_pkg::NUM_LANES-1:0] lane_cmp;
   stc_pkg::compare_type [stc_pkg::NUM_LANES-1:0] frame_data;
   logic [FW-1:0]                                 rd_data;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         joint_band_ff   <= stc_pkg::JOINT_BAND_RESET;
         claw_live_ff    <= stc_pkg::CLAW_LIVE_RESET;
         claw_record_ff  <= stc_pkg::CLAW_RECORD_RESET;
         claw_release_ff <= stc_pkg::CLAW_RELEASE_RESET;
      end else if (csr_bus.valid) begin
         unique case (stc_pkg::csr_index_type'(csr_bus.index))
            stc_pkg::CSR_JOINT_DEADBAND: joint_band_ff   <= csr_bus.data;
            stc_pkg::CSR_CLAW_LIVE:      claw_live_ff    <= csr_bus.data;
            stc_pkg::CSR_CLAW_RECORD:    claw_record_ff  <= csr_bus.data;
            stc_pkg::CSR_CLAW_RELEASE:   claw_release_ff <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   assign accept        = req_bus.valid && stage_free;
   assign req_bus.ready = stage_free;
   assign command       = stc_pkg::command_type'(req_bus.command);

   always_comb begin
      frame_count_in   = frame_count_ff;
      replay_ptr_in    = replay_ptr_ff;
      sample_en        = 1'b0;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      claw_band        = claw_live_ff;
      ctl.from_frame   = 1'b0;
      ctl.status       = stc_pkg::ST_OK;
      ctl.last_frame   = 1'b0;
      if (accept) begin
         unique case (command)
            stc_pkg::CMD_LIVE: begin
               sample_en = 1'b1;
            end
            stc_pkg::CMD_START_RECORD: begin
               frame_count_in = '0;
               replay_ptr_in  = '0;
            end
            stc_pkg::CMD_RECORD: begin
               sample_en = 1'b1;
               claw_band = claw_record_ff;
               if (frame_count_ff < DEPTH_LIMIT) begin
                  wr_en          = 1'b1;
                  frame_count_in = frame_count_ff + 1'b1;
               end else begin
                  ctl.status = stc_pkg::ST_FULL;
               end
            end
            stc_pkg::CMD_START_REPLAY: begin
               replay_ptr_in = '0;
            end
            stc_pkg::CMD_REPLAY_TICK: begin
               if (replay_ptr_ff < frame_count_ff) begin
                  rd_en          = 1'b1;
                  ctl.from_frame = 1'b1;
                  replay_ptr_in  = replay_ptr_ff + 1'b1;
                  ctl.last_frame = (replay_ptr_in == frame_count_ff);
               end else begin
                  ctl.status = stc_pkg::ST_EXHAUSTED;
               end
            end
            default: begin
            end
         endcase
      end
      count_wide        = {8'b0, frame_count_in};
      ctl.frames_stored = count_wide[7:0];
      ctl.claw_released = lane_next[stc_pkg::CLAW_LANE].sample > claw_release_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         replay_ptr_ff  <= '0;
      end else begin
         frame_count_ff <= frame_count_in;
         replay_ptr_ff  <= replay_ptr_in;
      end
   end

   assign samples = {req_bus.claw_sample, req_bus.elbow_sample,
                     req_bus.shoulder_sample, req_bus.base_sample};
   assign bands   = {claw_band, joint_band_ff, joint_band_ff, joint_band_ff};

   for (genvar i = 0; i < stc_pkg::NUM_LANES; i++) begin : g_lane
      stc_lane #(
         .IS_CLAW (i == stc_pkg::CLAW_LANE)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .sample_en (sample_en),
         .sample    (samples[i]),
         .band      (bands[i]),
         .lane_next (lane_next[i])
      );
      assign lane_cmp[i] = lane_next[i].compare;
   end

   stc_ram #(
      .WIDTH (FW),
      .DEPTH (FRAME_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (frame_count_ff[AW-1:0]),
      .wr_data (lane_cmp),
      .rd_en   (rd_en),
      .rd_addr (replay_ptr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign frame_data = rd_data;

   stc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .lane_cmp   (lane_cmp),
      .ctl        (ctl),
      .frame_data (frame_data),
      .stage_free (stage_free),
      .rsp        (rsp_bus)
   );

   `STC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, frame_count_ff <= DEPTH_LIMIT)
   `STC_ASSERT_NOW(a_ptr_bound, clock, reset, 1'b1, replay_ptr_ff <= frame_count_ff)
   `STC_ASSERT_NEXT(a_record_adv, clock, reset, wr_en, frame_count_ff == $past(frame_count_ff) + 1'b1)
   `STC_ASSERT_NEXT(a_tick_adv, clock, reset, rd_en, replay_ptr_ff == $past(replay_ptr_ff) + 1'b1)

endmodule
